[sv/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg
// shared sizes, command and status codes and scan unit types for the
// sparse slot table
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int DEPTH       = 256;
   localparam int GROUPS      = 16;
   localparam int GROUP_SIZE  = DEPTH / GROUPS;
   localparam int VALUE_W     = 32;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int GRP_W       = $clog2(GROUPS);
   localparam int OFF_W       = $clog2(GROUP_SIZE);
   localparam int SLOT_W      = 9;
   localparam int CNT_W       = $clog2(GROUP_SIZE + 1);
   localparam int CMD_W       = 2;
   localparam int STAT_W      = 2;

   localparam logic [SLOT_W-1:0] CAP_MAX        = SLOT_W'(DEPTH);
   localparam logic [CNT_W-1:0]  GRP_CNT_INIT   = CNT_W'(GROUP_SIZE);
   localparam logic [GRP_W-1:0]  LAST_GROUP     = GRP_W'(GROUPS - 1);

   localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FIND    = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [GRP_W-1:0]      group;
      logic [SLOT_W-1:0]     lo;
      logic [SLOT_W-1:0]     cap;
      logic [GROUP_SIZE-1:0] bits;
   } scan_req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] index;
   } scan_rsp_type;

endpackage

[sv/sst_slot_ram.sv]
// ----------------------------------------------------------------------------
// sst_slot_ram
// handle value storage, one write and one registered read port
// ----------------------------------------------------------------------------
module sst_slot_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [sst_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [sst_pkg::VALUE_W-1:0] wr_data,
   input  logic [sst_pkg::ADDR_W-1:0]  rd_addr,
   output logic [sst_pkg::VALUE_W-1:0] rd_data
);
   import sst_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sst_group_scan.sv]
// ----------------------------------------------------------------------------
// sst_group_scan
// lowest set bit of one group's slot mask, bounded below by a start index
// and above by the capacity
// ----------------------------------------------------------------------------
module sst_group_scan (
   input  sst_pkg::scan_req_type scan_req,
   output sst_pkg::scan_rsp_type scan_rsp
);
   import sst_pkg::*;

   always_comb begin
      logic [SLOT_W-1:0] cand;
      cand           = '0;
      scan_rsp.hit   = 1'b0;
      scan_rsp.index = '0;
      // walk down so the lowest qualifying slot wins
      for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
         cand = {1'b0, scan_req.group, OFF_W'(j)};
         if (scan_req.bits[j] && (cand >= scan_req.lo) && (cand < scan_req.cap)) begin
            scan_rsp.hit   = 1'b1;
            scan_rsp.index = cand;
         end
      end
   end

endmodule

[sv/sparse_slot_table_core.sv]
// ----------------------------------------------------------------------------
// sparse_slot_table_core
// handle table of 256 slots in 16 groups with per-group free counts;
// read, write, release and find-next-occupied commands, every result
// also carries the lowest free slot, a full flag and the occupied count
// ----------------------------------------------------------------------------
//
// channel   ports                          direction  beat taken when
// request   start, req_*                   in         start && !busy
// response  rsp_valid, rsp_*               out        rsp_valid (one cycle)
// config    csr_wr_en, csr_wr_data         in         csr_wr_en
//
// - one command at a time: accept, the execute state, then a group scan for
//   find-next-occupied (one group of 16 slots per cycle) and a group scan
//   for the lowest free slot, both on the shared group scan unit
// - rsp_valid rises after the execute state and the group scans, registered
//   from the last free-scan state; busy drops as the beat shows, so the
//   next start can be taken in that same cycle
// - reset (synchronous) sets capacity to 256, clears the used map and the
//   count; the value memory is not cleared, an empty slot reads as zero
// - a capacity write clears the table the same way
// - the receiver cannot stall: each response beat is shown for a single cycle
//
module sparse_slot_table_core (
   input  logic                         clock,
   input  logic                         reset,
   // request
   input  logic                         start,
   output logic                         busy,
   input  logic [sst_pkg::CMD_W-1:0]    req_command,
   input  logic [sst_pkg::SLOT_W-1:0]   req_slot_index,
   input  logic [sst_pkg::VALUE_W-1:0]  req_write_value,
   // response
   output logic                         rsp_valid,
   output logic [sst_pkg::STAT_W-1:0]   rsp_status,
   output logic [sst_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [sst_pkg::SLOT_W-1:0]   rsp_found_index,
   output logic [sst_pkg::ADDR_W-1:0]   rsp_first_free_index,
   output logic                         rsp_table_full,
   output logic [sst_pkg::SLOT_W-1:0]   rsp_item_count,
   // capacity register
   input  logic                         csr_wr_en,
   input  logic [sst_pkg::SLOT_W-1:0]   csr_wr_data
);
   import sst_pkg::*;

   // sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_OCC  = 2'd2;
   localparam logic [1:0] ST_FREE = 2'd3;

   logic [1:0] state_ff, state_in;

   // latched command
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [VALUE_W-1:0] val_ff, val_in;

   // scan progress and partial result
   logic [GRP_W-1:0]   grp_ff, grp_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [SLOT_W-1:0]  found_ff, found_in;

   // table state
   logic [SLOT_W-1:0]                       capacity_ff, capacity_in;
   logic [GROUPS-1:0][GROUP_SIZE-1:0]       used_ff, used_in;
   logic [GROUPS-1:0][CNT_W-1:0]            count_ff, count_in;
   logic [SLOT_W-1:0]                       total_ff, total_in;

   // response registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic [SLOT_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [ADDR_W-1:0]  rsp_free_ff, rsp_free_in;
   logic               rsp_full_ff, rsp_full_in;
   logic [SLOT_W-1:0]  rsp_count_ff, rsp_count_in;

   // combinational helpers
   logic [SLOT_W-1:0]  cap_eff;
   logic               idx_good;
   logic [GRP_W-1:0]   idx_grp;
   logic [OFF_W-1:0]   idx_off;
   logic               idx_used;
   logic               exec_set;
   logic               exec_clr;
   logic               ram_we;
   logic [VALUE_W-1:0] ram_rdata;

   scan_req_type scan_req;
   scan_rsp_type scan_rsp;

   // capacity above the table size uses the whole table
   assign cap_eff  = (capacity_ff > CAP_MAX) ? CAP_MAX : capacity_ff;
   assign idx_good = idx_ff < cap_eff;
   assign idx_grp  = idx_ff[ADDR_W-1:OFF_W];
   assign idx_off  = idx_ff[OFF_W-1:0];
   assign idx_used = used_ff[idx_grp][idx_off];

   // table updates done in the execute cycle; writing zero is a release
   always_comb begin
      exec_set = 1'b0;
      exec_clr = 1'b0;
      ram_we   = 1'b0;
      if (state_ff == ST_EXEC && idx_good) begin
         if (cmd_ff == CMD_WRITE && val_ff != '0) begin
            ram_we   = 1'b1;
            exec_set = !idx_used;
         end
         if ((cmd_ff == CMD_WRITE && val_ff == '0) || cmd_ff == CMD_RELEASE) begin
            exec_clr = idx_used;
         end
      end
   end

   sst_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff[ADDR_W-1:0]),
      .wr_data (val_ff),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // the one scan unit, shared by the occupied search and the free search;
   // a group whose free count is zero is skipped in the free search
   always_comb begin
      scan_req.group = grp_ff;
      scan_req.cap   = cap_eff;
      if (state_ff == ST_OCC) begin
         scan_req.lo   = idx_ff;
         scan_req.bits = used_ff[grp_ff];
      end else begin
         scan_req.lo   = '0;
         scan_req.bits = ~used_ff[grp_ff] & {GROUP_SIZE{count_ff[grp_ff] != '0}};
      end
   end

   sst_group_scan u_scan (
      .scan_req (scan_req),
      .scan_rsp (scan_rsp)
   );

   // sequencer and next-state logic
   always_comb begin
      state_in          = state_ff;
      cmd_in            = cmd_ff;
      idx_in            = idx_ff;
      val_in            = val_ff;
      grp_in            = grp_ff;
      status_in         = status_ff;
      found_in          = found_ff;
      capacity_in       = capacity_ff;
      used_in           = used_ff;
      count_in          = count_ff;
      total_in          = total_ff;
      rsp_valid_in      = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_found_in      = rsp_found_ff;
      rsp_free_in       = rsp_free_ff;
      rsp_full_in       = rsp_full_ff;
      rsp_count_in      = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_command;
               idx_in   = req_slot_index;
               val_in   = req_write_value;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = STAT_OK;
            found_in  = '0;
            grp_in    = '0;
            state_in  = ST_FREE;
            unique case (cmd_ff)
               CMD_READ, CMD_WRITE: begin
                  if (!idx_good) begin
                     status_in = STAT_BAD_INDEX;
                  end
               end
               CMD_RELEASE: begin
                  // bad index is ignored on release
               end
               CMD_FIND: begin
                  if (!idx_good) begin
                     status_in = STAT_BAD_INDEX;
                     found_in  = cap_eff;
                  end else begin
                     grp_in   = idx_grp;
                     state_in = ST_OCC;
                  end
               end
            endcase
            if (exec_set) begin
               used_in[idx_grp][idx_off] = 1'b1;
               count_in[idx_grp]         = count_ff[idx_grp] - CNT_W'(1);
               total_in                  = total_ff + SLOT_W'(1);
            end
            if (exec_clr) begin
               used_in[idx_grp][idx_off] = 1'b0;
               count_in[idx_grp]         = count_ff[idx_grp] + CNT_W'(1);
               total_in                  = total_ff - SLOT_W'(1);
            end
         end
         ST_OCC: begin
            if (scan_rsp.hit) begin
               found_in = scan_rsp.index;
               grp_in   = '0;
               state_in = ST_FREE;
            end else if (grp_ff == LAST_GROUP) begin
               found_in  = cap_eff;
               status_in = STAT_NOT_FOUND;
               grp_in    = '0;
               state_in  = ST_FREE;
            end else begin
               grp_in = grp_ff + GRP_W'(1);
            end
         end
         ST_FREE: begin
            if (scan_rsp.hit || grp_ff == LAST_GROUP) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               // memory data is stable here, addressed since the execute cycle
               rsp_read_value_in = (cmd_ff == CMD_READ && status_ff == STAT_OK && idx_used)
                                   ? ram_rdata : '0;
               rsp_found_in  = found_ff;
               rsp_free_in   = scan_rsp.hit ? scan_rsp.index[ADDR_W-1:0] : '0;
               rsp_full_in   = !scan_rsp.hit;
               rsp_count_in  = total_ff;
            end else begin
               grp_in = grp_ff + GRP_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capacity write re-initializes the table
      if (csr_wr_en) begin
         capacity_in = csr_wr_data;
         used_in     = '0;
         count_in    = {GROUPS{GRP_CNT_INIT}};
         total_in    = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAP_MAX;
         used_ff      <= '0;
         count_ff     <= {GROUPS{GRP_CNT_INIT}};
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff            <= cmd_in;
      idx_ff            <= idx_in;
      val_ff            <= val_in;
      grp_ff            <= grp_in;
      status_ff         <= status_in;
      found_ff          <= found_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_free_ff       <= rsp_free_in;
      rsp_full_ff       <= rsp_full_in;
      rsp_count_ff      <= rsp_count_in;
   end

   assign busy                 = state_ff != ST_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_read_value       = rsp_read_value_ff;
   assign rsp_found_index      = rsp_found_ff;
   assign rsp_first_free_index = rsp_free_ff;
   assign rsp_table_full       = rsp_full_ff;
   assign rsp_item_count       = rsp_count_ff;

   // occupied count tracks the used map
   a_total_matches_map: assert property (@(posedge clock) disable iff (reset)
      total_ff == SLOT_W'($countones(used_ff)))
      else $error("occupied count out of step with used map");

   // a command that ends always produces its response beat
   a_done_gives_beat: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("sequencer went idle without a response");

   // a response beat is only shown while idle
   a_beat_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   // an accepted command starts the sequencer
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not start");

   // a full table reports slot zero as first free
   a_full_free_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> rsp_first_free_index == '0)
      else $error("first free index set on a full table");

endmodule
